// ===== rtl/mlfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mlfs_pkg: shared types and constants for the multi-level FIFO set
// Field widths, register map, request/entry records and store commands.
// ----------------------------------------------------------------------------
package mlfs_pkg;

   localparam int CAP_W         = 9;
   localparam int PCT_W         = 7;
   localparam int NUM_CAP_REGS  = 4;
   localparam int PERCENT_SCALE = 100;

   localparam int REQ_LEVEL_W = 8;
   localparam int START_W     = 32;
   localparam int COUNT_W     = 16;
   localparam int USED_W      = 2;
   localparam int TOTAL_W     = 11;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 9'd64;
   localparam logic [PCT_W-1:0] PCT_RESET = 7'd50;

   localparam logic KIND_PUSH = 1'b0;
   localparam logic KIND_POP  = 1'b1;

   typedef enum logic [2:0] {
      REG_LEVEL0_CAP = 3'd0,
      REG_LEVEL1_CAP = 3'd1,
      REG_LEVEL2_CAP = 3'd2,
      REG_LEVEL3_CAP = 3'd3,
      REG_REFILL_PCT = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic                   kind;
      logic [REQ_LEVEL_W-1:0] req_level;
      logic                   strict_level;
      logic [START_W-1:0]     blk_start;
      logic [COUNT_W-1:0]     blk_count;
   } req_type;

   typedef struct packed {
      logic [REQ_LEVEL_W-1:0] tag;
      logic [COUNT_W-1:0]     count;
      logic [START_W-1:0]     start;
   } entry_type;

   typedef struct packed {
      logic wr;
      logic rd;
   } st_cmd_type;

endpackage

// ===== rtl/mlfs_if.sv =====
// ----------------------------------------------------------------------------
// mlfs_if: request and response channels
// Valid/ready channels carrying the request and response payloads.
// ----------------------------------------------------------------------------
interface mlfs_req_if import mlfs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   kind;
   logic [REQ_LEVEL_W-1:0] req_level;
   logic                   strict_level;
   logic [START_W-1:0]     blk_start;
   logic [COUNT_W-1:0]     blk_count;

   modport source (output valid, kind, req_level, strict_level, blk_start, blk_count,
                   input ready);
   modport sink (input valid, kind, req_level, strict_level, blk_start, blk_count,
                 output ready);
endinterface

interface mlfs_rsp_if import mlfs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   ok;
   logic [USED_W-1:0]      level_used;
   logic [START_W-1:0]     out_start;
   logic [COUNT_W-1:0]     out_count;
   logic [REQ_LEVEL_W-1:0] out_tag;
   logic [TOTAL_W-1:0]     total_entries;
   logic                   below_refill;

   modport source (output valid, ok, level_used, out_start, out_count, out_tag,
                   total_entries, below_refill, input ready);
   modport sink (input valid, ok, level_used, out_start, out_count, out_tag,
                 total_entries, below_refill, output ready);
endinterface

// ===== rtl/mlfs_csr.sv =====
// ----------------------------------------------------------------------------
// mlfs_csr: configuration registers
// APB register file, effective level capacities and refill product.
// ----------------------------------------------------------------------------
module mlfs_csr import mlfs_pkg::*; #(
   parameter int NUM_LEVELS  = 4,
   parameter int LEVEL_DEPTH = 256,
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1),
   localparam int TCAP_W = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1),
   localparam int PROD_W = TCAP_W + PCT_W
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [CSR_ADDR_W-1:0]             paddr,
   input  logic [CSR_DATA_W-1:0]             pwdata,
   output logic [CSR_DATA_W-1:0]             prdata,
   output logic [NUM_LEVELS-1:0][CNT_W-1:0]  eff_cap,
   output logic [PROD_W-1:0]                 refill_prod
);

   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   logic [CAP_W-1:0]  cap_ff [NUM_CAP_REGS];
   logic [CAP_W-1:0]  cap_in [NUM_CAP_REGS];
   logic [PCT_W-1:0]  pct_ff;
   logic [PCT_W-1:0]  pct_in;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [TCAP_W-1:0] totcap;
   logic              wr_en;
   reg_index_type     reg_idx;

   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = reg_index_type'(paddr[4:2]);

   always_comb begin
      for (int i = 0; i < NUM_CAP_REGS; i++) begin
         cap_in[i] = cap_ff[i];
      end
      pct_in = pct_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_LEVEL0_CAP: cap_in[0] = pwdata[CAP_W-1:0];
            REG_LEVEL1_CAP: cap_in[1] = pwdata[CAP_W-1:0];
            REG_LEVEL2_CAP: cap_in[2] = pwdata[CAP_W-1:0];
            REG_LEVEL3_CAP: cap_in[3] = pwdata[CAP_W-1:0];
            REG_REFILL_PCT: pct_in    = pwdata[PCT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_LEVEL0_CAP: prdata = CSR_DATA_W'(cap_ff[0]);
         REG_LEVEL1_CAP: prdata = CSR_DATA_W'(cap_ff[1]);
         REG_LEVEL2_CAP: prdata = CSR_DATA_W'(cap_ff[2]);
         REG_LEVEL3_CAP: prdata = CSR_DATA_W'(cap_ff[3]);
         REG_REFILL_PCT: prdata = CSR_DATA_W'(pct_ff);
         default:        prdata = '0;
      endcase
   end

   // capacity clipped to the FIFO depth; levels past the register list get full depth
   for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_cap
      if (l < NUM_CAP_REGS) begin : g_reg
         logic [CMP_W-1:0] cap_ext;
         assign cap_ext    = CMP_W'(cap_ff[l]);
         assign eff_cap[l] = (cap_ext > CMP_W'(LEVEL_DEPTH)) ? CNT_W'(LEVEL_DEPTH)
                                                              : CNT_W'(cap_ext);
      end else begin : g_fixed
         assign eff_cap[l] = CNT_W'(LEVEL_DEPTH);
      end
   end

   always_comb begin
      totcap = '0;
      for (int l = 0; l < NUM_LEVELS; l++) begin
         totcap = totcap + TCAP_W'(eff_cap[l]);
      end
      prod_in = PROD_W'(totcap) * PROD_W'(pct_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_CAP_REGS; i++) begin
            cap_ff[i] <= CAP_RESET;
         end
         pct_ff <= PCT_RESET;
      end else begin
         for (int i = 0; i < NUM_CAP_REGS; i++) begin
            cap_ff[i] <= cap_in[i];
         end
         pct_ff <= pct_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign refill_prod = prod_ff;

endmodule

// ===== rtl/mlfs_store.sv =====
// ----------------------------------------------------------------------------
// mlfs_store: entry memory
// One write or one read per cycle; read data registered and held.
// ----------------------------------------------------------------------------
module mlfs_store import mlfs_pkg::*; #(
   parameter int NUM_LEVELS  = 4,
   parameter int LEVEL_DEPTH = 256,
   localparam int LVL_W     = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
   localparam int IDX_W     = $clog2(LEVEL_DEPTH),
   localparam int ADDR_W    = LVL_W + IDX_W,
   localparam int MEM_DEPTH = NUM_LEVELS * (2 ** IDX_W)
) (
   input  logic              clock,
   input  st_cmd_type        cmd,
   input  logic [ADDR_W-1:0] addr,
   input  entry_type         wdata,
   output entry_type         rdata
);

   entry_type mem [MEM_DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[addr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) begin
         rdata_ff <= mem[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/mlfs_ctrl.sv =====
// ----------------------------------------------------------------------------
// mlfs_ctrl: level selection and FIFO pointers
// Picks the level with rotating fallback, keeps head/tail/fill and total.
// ----------------------------------------------------------------------------
module mlfs_ctrl import mlfs_pkg::*; #(
   parameter int NUM_LEVELS  = 4,
   parameter int LEVEL_DEPTH = 256,
   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1),
   localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
   localparam int IDX_W  = $clog2(LEVEL_DEPTH),
   localparam int ADDR_W = LVL_W + IDX_W,
   localparam int TOT_W  = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             advance,
   input  req_type                          req,
   input  logic [NUM_LEVELS-1:0][CNT_W-1:0] eff_cap,
   output logic                             ok,
   output logic [LVL_W-1:0]                 sel_lvl,
   output logic [TOT_W-1:0]                 total_next,
   output st_cmd_type                       st_cmd,
   output logic [ADDR_W-1:0]                st_addr
);

   logic [IDX_W-1:0] head_ff [NUM_LEVELS];
   logic [IDX_W-1:0] head_in [NUM_LEVELS];
   logic [IDX_W-1:0] tail_ff [NUM_LEVELS];
   logic [IDX_W-1:0] tail_in [NUM_LEVELS];
   logic [CNT_W-1:0] fill_ff [NUM_LEVELS];
   logic [CNT_W-1:0] fill_in [NUM_LEVELS];
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] total_in;
   logic [NUM_LEVELS-1:0] avail;
   logic [LVL_W-1:0] start_lvl;
   logic             is_pop;
   logic             commit;

   function automatic logic [IDX_W-1:0] idx_next(input logic [IDX_W-1:0] idx);
      return (idx == IDX_W'(LEVEL_DEPTH - 1)) ? '0 : idx + 1'b1;
   endfunction

   assign is_pop = (req.kind == KIND_POP);

   assign start_lvl = (req.req_level >= REQ_LEVEL_W'(NUM_LEVELS - 1))
                    ? LVL_W'(NUM_LEVELS - 1) : LVL_W'(req.req_level);

   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         avail[l] = is_pop ? (fill_ff[l] != '0) : (fill_ff[l] < eff_cap[l]);
      end
   end

   // rotating search from the start level; strict stops after the first try
   always_comb begin
      logic [LVL_W-1:0] idx;
      logic             found;
      idx     = start_lvl;
      found   = 1'b0;
      sel_lvl = start_lvl;
      for (int k = 0; k < NUM_LEVELS; k++) begin
         if (!found && (k == 0 || !req.strict_level) && avail[idx]) begin
            found   = 1'b1;
            sel_lvl = idx;
         end
         idx = (idx == LVL_W'(NUM_LEVELS - 1)) ? '0 : idx + 1'b1;
      end
      ok = found;
   end

   assign commit    = advance && ok;
   assign st_cmd.wr = commit && !is_pop;
   assign st_cmd.rd = commit && is_pop;
   assign st_addr   = {sel_lvl, is_pop ? head_ff[sel_lvl] : tail_ff[sel_lvl]};

   always_comb begin
      for (int l = 0; l < NUM_LEVELS; l++) begin
         head_in[l] = head_ff[l];
         tail_in[l] = tail_ff[l];
         fill_in[l] = fill_ff[l];
         if (commit && sel_lvl == LVL_W'(l)) begin
            if (is_pop) begin
               head_in[l] = idx_next(head_ff[l]);
               fill_in[l] = fill_ff[l] - 1'b1;
            end else begin
               tail_in[l] = idx_next(tail_ff[l]);
               fill_in[l] = fill_ff[l] + 1'b1;
            end
         end
      end
      if (ok) begin
         total_next = is_pop ? total_ff - 1'b1 : total_ff + 1'b1;
      end else begin
         total_next = total_ff;
      end
      total_in = advance ? total_next : total_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l] <= '0;
            tail_ff[l] <= '0;
            fill_ff[l] <= '0;
         end
         total_ff <= '0;
      end else begin
         for (int l = 0; l < NUM_LEVELS; l++) begin
            head_ff[l] <= head_in[l];
            tail_ff[l] <= tail_in[l];
            fill_ff[l] <= fill_in[l];
         end
         total_ff <= total_in;
      end
   end

`ifndef SYNTH
   for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_chk
      a_fill_bound: assert property (@(posedge clock) disable iff (reset)
         fill_ff[l] <= CNT_W'(LEVEL_DEPTH))
         else $error("level fill above FIFO depth");
      a_full_ptrs: assert property (@(posedge clock) disable iff (reset)
         (fill_ff[l] == CNT_W'(LEVEL_DEPTH)) |-> (head_ff[l] == tail_ff[l]))
         else $error("full level with head and tail apart");
   end
   a_total_hold: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(total_ff))
      else $error("total changed without an operation");
   a_strict_lvl: assert property (@(posedge clock) disable iff (reset)
      (advance && ok && req.strict_level) |-> (sel_lvl == start_lvl))
      else $error("strict request served from another level");
`endif

endmodule

// ===== rtl/multi_level_fifo_set.sv =====
// ----------------------------------------------------------------------------
// multi_level_fifo_set: bounded FIFO set with per-level fallback
// Top level: request register, level control, entry store, response register.
// ----------------------------------------------------------------------------
// Usage:
//   req  - valid/ready request: push (kind 0) stores {blk_start, blk_count,
//          req_level} in the level picked from req_level (clamped to the last
//          level); pop (kind 1) removes the oldest entry of the picked level.
//          Without strict_level a full (push) or empty (pop) level falls back
//          to the next levels in rotating order.
//   rsp  - one response per request: ok, level used, popped entry (zero on
//          push or failure), total entries and the below-refill flag.
//   APB  - level capacities and refill percent; write only while idle.
// Timing: a request is registered in the input register at acceptance, then resolved
//   and written to the response register when that register is free or being
//   drained; one request per cycle sustained while rsp.ready stays high. The level
//   search and the store access share the same cycle.
// Reset: all FIFOs empty, capacities 64, refill percent 50. No clearing pass.
// Stall: a held response keeps one more request parked in the input register;
//   req.ready drops only when both registers are full.
// ----------------------------------------------------------------------------
module multi_level_fifo_set import mlfs_pkg::*; #(
   parameter int NUM_LEVELS  = 4,
   parameter int LEVEL_DEPTH = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   mlfs_req_if.sink              req,
   mlfs_rsp_if.source            rsp,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
   localparam int LVL_W  = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
   localparam int IDX_W  = $clog2(LEVEL_DEPTH);
   localparam int ADDR_W = LVL_W + IDX_W;
   localparam int TOT_W  = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1);
   localparam int TCAP_W = $clog2(NUM_LEVELS * LEVEL_DEPTH + 1);
   localparam int PROD_W = TCAP_W + PCT_W;
   localparam int BW     = (PROD_W > TOT_W + 8) ? PROD_W : TOT_W + 8;

   // request stage
   logic    s1_valid_ff;
   logic    s1_valid_in;
   req_type s1_req_ff;
   logic    req_take;
   logic    advance;

   // response stage
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic              ok_ff;
   logic [USED_W-1:0] used_ff;
   logic              pop_ff;
   logic [TOT_W-1:0]  total_ff;

   // between units
   logic [NUM_LEVELS-1:0][CNT_W-1:0] eff_cap;
   logic [PROD_W-1:0] refill_prod;
   logic              ok;
   logic [LVL_W-1:0]  sel_lvl;
   logic [TOT_W-1:0]  total_next;
   st_cmd_type        st_cmd;
   logic [ADDR_W-1:0] st_addr;
   entry_type         st_wdata;
   entry_type         st_rdata;
   logic              show_entry;
   logic [BW-1:0]     need_prod;

   assign pready = 1'b1;

   // the request moves on when the response register is free or being drained
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || advance;
   assign req_take  = req.valid && req.ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_req_ff.kind         <= req.kind;
         s1_req_ff.req_level    <= req.req_level;
         s1_req_ff.strict_level <= req.strict_level;
         s1_req_ff.blk_start    <= req.blk_start;
         s1_req_ff.blk_count    <= req.blk_count;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ok_ff    <= ok;
         used_ff  <= USED_W'(sel_lvl);
         pop_ff   <= (s1_req_ff.kind == KIND_POP);
         total_ff <= total_next;
      end
   end

   mlfs_csr #(
      .NUM_LEVELS  (NUM_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .eff_cap     (eff_cap),
      .refill_prod (refill_prod)
   );

   mlfs_ctrl #(
      .NUM_LEVELS  (NUM_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .req        (s1_req_ff),
      .eff_cap    (eff_cap),
      .ok         (ok),
      .sel_lvl    (sel_lvl),
      .total_next (total_next),
      .st_cmd     (st_cmd),
      .st_addr    (st_addr)
   );

   // entry tag is the requested level as given, not clamped
   assign st_wdata.tag   = s1_req_ff.req_level;
   assign st_wdata.count = s1_req_ff.blk_count;
   assign st_wdata.start = s1_req_ff.blk_start;

   mlfs_store #(
      .NUM_LEVELS  (NUM_LEVELS),
      .LEVEL_DEPTH (LEVEL_DEPTH)
   ) u_store (
      .clock (clock),
      .cmd   (st_cmd),
      .addr  (st_addr),
      .wdata (st_wdata),
      .rdata (st_rdata)
   );

   // store read data is only meaningful after a successful pop
   assign show_entry = ok_ff && pop_ff;

   // total < floor(totcap * pct / 100)  <=>  100 * (total + 1) <= totcap * pct
   assign need_prod = (BW'(total_ff) + BW'(1)) * BW'(PERCENT_SCALE);

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.ok            = ok_ff;
   assign rsp.level_used    = used_ff;
   assign rsp.out_start     = show_entry ? st_rdata.start : '0;
   assign rsp.out_count     = show_entry ? st_rdata.count : '0;
   assign rsp.out_tag       = show_entry ? st_rdata.tag : '0;
   assign rsp.total_entries = TOTAL_W'(total_ff);
   assign rsp.below_refill  = (need_prod <= BW'(refill_prod));

endmodule
